// ----- rtl/csb_pkg.sv -----
// shared constants, codes and control types for the counting semaphore bank
`timescale 1ns / 1ps
`default_nettype none

package csb_pkg;

   // sizing
   localparam int NUM_RESOURCES = 4;
   localparam int QUEUE_DEPTH   = 16;
   localparam int PID_BITS      = 8;

   // field widths
   localparam int RES_BITS    = 4;
   localparam int ID_BITS     = 8;
   localparam int STATUS_BITS = 2;
   localparam int CNT_BITS    = 9;
   localparam int RIU_BITS    = 3;
   localparam int INIT_BITS   = 8;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 8;
   localparam int REQ_DATA_BITS = 16;
   localparam int RSP_DATA_BITS = 24;

   // derived widths
   localparam int RIDX_BITS = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
   localparam int PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int FILL_BITS = PTR_BITS + 1;
   localparam int STORE_DEPTH = NUM_RESOURCES * QUEUE_DEPTH;
   localparam int ADDR_BITS = $clog2(STORE_DEPTH);

   // count limits
   localparam int CNT_TOP = 255;

   // operations
   localparam logic OP_WAIT   = 1'b0;
   localparam logic OP_SIGNAL = 1'b1;

   // status codes
   localparam logic [STATUS_BITS-1:0] ST_CONTINUE = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_BLOCKED  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_UNKNOWN  = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_RES_IN_USE = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INIT_0     = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INIT_1     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INIT_2     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INIT_3     = 3'd4;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic execute;
      logic load;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;
   } ctrl_stat_type;

endpackage

`default_nettype wire

// ----- rtl/counting_semaphore_bank_top.sv -----
// top level of the counting semaphore bank
// a request is captured, executed into the pending result registers, then loaded into the
// output register once it is free; only then is the next request accepted
// a popped waiter id is read from the waiter store ram during the execute cycle
// reset (synchronous, active high): 4 resources in use, every count 1, all queues empty
// the waiter store is not cleared; only entries that were pushed are ever read
`timescale 1ns / 1ps
`default_nettype none

module counting_semaphore_bank_top
   import csb_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,  // op, resource[3:0], process_id[7:0], pad
   // result channel
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic      [RSP_DATA_BITS-1:0] rsp_tdata,  // status[1:0], woken_valid, woken_id[7:0],
                                                      // count_after[8:0], pad
   // register writes
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   csb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   csb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

`default_nettype wire

// ----- rtl/csb_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module csb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/csb_ctrl.sv -----
// controller state machine: accept, execute, hand result to output register
`timescale 1ns / 1ps
`default_nettype none

module csb_ctrl
   import csb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire ctrl_stat_type stat,
   output ctrl_cmd_type       cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready  = (state_ff == S_IDLE);
   assign cmd.capture = req_tvalid && (state_ff == S_IDLE);
   assign cmd.execute = (state_ff == S_EXEC);
   assign cmd.load    = (state_ff == S_DONE) && stat.out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: state_in = S_DONE;
         S_DONE: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/csb_datapath.sv -----
// datapath: counters, queue pointers, waiter store and result register
`timescale 1ns / 1ps
`default_nettype none

module csb_datapath
   import csb_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ctrl_cmd_type             cmd,
   output ctrl_stat_type                 stat,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic      [RSP_DATA_BITS-1:0] rsp_tdata,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // captured request
   logic                op_ff;
   logic [RES_BITS-1:0] res_ff;
   logic [PID_BITS-1:0] pid_ff;

   // configuration and per-resource state
   logic [RIU_BITS-1:0]         riu_ff;
   logic signed [CNT_BITS-1:0]  count_ff [NUM_RESOURCES];
   logic signed [CNT_BITS-1:0]  count_in [NUM_RESOURCES];
   logic [PTR_BITS-1:0]         head_ff  [NUM_RESOURCES];
   logic [PTR_BITS-1:0]         head_in  [NUM_RESOURCES];
   logic [PTR_BITS-1:0]         tail_ff  [NUM_RESOURCES];
   logic [PTR_BITS-1:0]         tail_in  [NUM_RESOURCES];
   logic [FILL_BITS-1:0]        fill_ff  [NUM_RESOURCES];
   logic [FILL_BITS-1:0]        fill_in  [NUM_RESOURCES];

   // pending result
   logic [STATUS_BITS-1:0]     pend_status_ff, pend_status_in;
   logic                       pend_wvalid_ff, pend_wvalid_in;
   logic signed [CNT_BITS-1:0] pend_count_ff,  pend_count_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;

   // execute-stage decode
   logic [RIDX_BITS-1:0]       ridx;
   logic                       known;
   logic signed [CNT_BITS-1:0] cnt;
   logic signed [CNT_BITS-1:0] cnt_dec;
   logic signed [CNT_BITS-1:0] cnt_inc;
   logic [FILL_BITS-1:0]       fill;
   logic                       push;
   logic                       pop;
   logic signed [CNT_BITS-1:0] new_count;
   logic [STATUS_BITS-1:0]     new_status;

   // waiter store ports
   logic [ADDR_BITS-1:0] wr_addr;
   logic [ADDR_BITS-1:0] rd_addr;
   logic [PID_BITS-1:0]  rd_data;
   logic [ID_BITS-1:0]   woken_id;
   logic [CSR_IDX_BITS-1:0] reload_idx;

   assign ridx    = res_ff[RIDX_BITS-1:0];
   assign known   = ({1'b0, res_ff} < {2'b00, riu_ff})
                 && ({1'b0, res_ff} < (RES_BITS+1)'(NUM_RESOURCES));
   assign cnt     = count_ff[ridx];
   assign fill    = fill_ff[ridx];
   assign cnt_dec = cnt - CNT_BITS'(1);
   assign cnt_inc = cnt + CNT_BITS'(1);

   // semaphore operation
   always_comb begin
      push       = 1'b0;
      pop        = 1'b0;
      new_count  = cnt;
      new_status = ST_CONTINUE;
      if (op_ff == OP_WAIT) begin
         if (cnt_dec < 0) begin
            if (fill == FILL_BITS'(QUEUE_DEPTH)) begin
               new_status = ST_FULL;
            end else begin
               push       = 1'b1;
               new_count  = cnt_dec;
               new_status = ST_BLOCKED;
            end
         end else begin
            new_count = cnt_dec;
         end
      end else begin
         if (cnt < CNT_BITS'(CNT_TOP)) begin
            new_count = cnt_inc;
            pop       = (cnt_inc <= 0) && (fill != '0);
         end
      end
   end

   // per-resource state update, config reload wins
   assign reload_idx = csr_index - CSR_INIT_0;
   always_comb begin
      for (int k = 0; k < NUM_RESOURCES; k++) begin
         count_in[k] = count_ff[k];
         head_in[k]  = head_ff[k];
         tail_in[k]  = tail_ff[k];
         fill_in[k]  = fill_ff[k];
      end
      if (cmd.execute && known) begin
         count_in[ridx] = new_count;
         if (push) begin
            tail_in[ridx] = tail_ff[ridx] + PTR_BITS'(1);
            fill_in[ridx] = fill_ff[ridx] + FILL_BITS'(1);
         end
         if (pop) begin
            head_in[ridx] = head_ff[ridx] + PTR_BITS'(1);
            fill_in[ridx] = fill_ff[ridx] - FILL_BITS'(1);
         end
      end
      if (csr_we && (csr_index >= CSR_INIT_0) && (csr_index <= CSR_INIT_3)) begin
         for (int k = 0; k < NUM_RESOURCES; k++) begin
            if (reload_idx == CSR_IDX_BITS'(k)) begin
               count_in[k] = CNT_BITS'(csr_wdata);
               head_in[k]  = '0;
               tail_in[k]  = '0;
               fill_in[k]  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         riu_ff <= RIU_BITS'(4);
         for (int k = 0; k < NUM_RESOURCES; k++) begin
            count_ff[k] <= CNT_BITS'(1);
            head_ff[k]  <= '0;
            tail_ff[k]  <= '0;
            fill_ff[k]  <= '0;
         end
      end else begin
         if (csr_we && (csr_index == CSR_RES_IN_USE)) begin
            riu_ff <= csr_wdata[RIU_BITS-1:0];
         end
         for (int k = 0; k < NUM_RESOURCES; k++) begin
            count_ff[k] <= count_in[k];
            head_ff[k]  <= head_in[k];
            tail_ff[k]  <= tail_in[k];
            fill_ff[k]  <= fill_in[k];
         end
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_tdata[0];
         res_ff <= req_tdata[RES_BITS:1];
         pid_ff <= req_tdata[RES_BITS+PID_BITS:RES_BITS+1];
      end
   end

   // waiter store: push writes at tail, pop reads at head
   assign wr_addr = {ridx, tail_ff[ridx]};
   assign rd_addr = {ridx, head_ff[ridx]};

   csb_ram #(
      .WIDTH (PID_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_waiters (
      .clock   (clock),
      .wr_en   (cmd.execute && known && push),
      .wr_addr (wr_addr),
      .wr_data (pid_ff),
      .rd_en   (cmd.execute && known && pop),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // pending result fields
   always_comb begin
      pend_status_in = pend_status_ff;
      pend_wvalid_in = pend_wvalid_ff;
      pend_count_in  = pend_count_ff;
      if (cmd.execute) begin
         if (known) begin
            pend_status_in = new_status;
            pend_wvalid_in = pop;
            pend_count_in  = new_count;
         end else begin
            pend_status_in = ST_UNKNOWN;
            pend_wvalid_in = 1'b0;
            pend_count_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_wvalid_ff <= pend_wvalid_in;
      pend_count_ff  <= pend_count_in;
   end

   // output register
   assign woken_id      = pend_wvalid_ff ? ID_BITS'(rd_data) : '0;
   assign stat.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in  = cmd.load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_data_ff <= {4'b0000, pend_count_ff, woken_id, pend_wvalid_ff, pend_status_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- tb/sv/counting_semaphore_bank_top_tb.sv -----
// self-checking testbench for the counting semaphore bank: random stream traffic, scoreboard
`timescale 1ns / 1ps

module counting_semaphore_bank_top_tb;
   import csb_pkg::*;

   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int RSP_HOLD_CYCLES = 48;
   localparam int SEGMENT_ITEMS   = 150;

   typedef struct packed {
      logic                op;
      logic [RES_BITS-1:0] resource;
      logic [ID_BITS-1:0]  pid;
   } semaphore_req_t;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic                   woken_valid;
      logic [ID_BITS-1:0]     woken_id;
      logic [CNT_BITS-1:0]    count_after;
   } semaphore_rsp_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // requests waiting to be offered, and outcomes predicted for accepted requests
   semaphore_req_t queued_requests[$];
   semaphore_rsp_t expected_outcomes[$];
   semaphore_req_t offered_req;

   // shadow of the bank: configuration, counts and per-resource wait rings
   int unsigned        res_in_use;
   int unsigned        init_value[NUM_RESOURCES];
   int                 sem_count[NUM_RESOURCES];
   logic [PID_BITS-1:0] waiter_ring[NUM_RESOURCES*QUEUE_DEPTH];
   int unsigned        ring_head[NUM_RESOURCES];
   int unsigned        ring_tail[NUM_RESOURCES];
   int unsigned        ring_fill[NUM_RESOURCES];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned stall_requests = 0;
   int unsigned stall_served = 0;
   int unsigned rsp_hold_left = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;

   counting_semaphore_bank_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // reload one resource: count from its register, wait ring emptied
   function automatic void reload_resource(int r);
      sem_count[r] = int'(init_value[r]);
      ring_head[r] = 0;
      ring_tail[r] = 0;
      ring_fill[r] = 0;
   endfunction

   // advance the shadow bank by one request and return the outcome it should give
   function automatic semaphore_rsp_t apply_semaphore_op(semaphore_req_t rq);
      semaphore_rsp_t o;
      int r;
      int lim;
      int nc;
      o = '0;
      r = int'(rq.resource);
      lim = (res_in_use < NUM_RESOURCES) ? int'(res_in_use) : NUM_RESOURCES;
      if (r >= lim) begin
         o.status = ST_UNKNOWN;
         return o;
      end
      if (rq.op == OP_WAIT) begin
         nc = sem_count[r] - 1;
         if (nc < 0) begin
            // caller must block, unless its ring is already full
            if (ring_fill[r] >= QUEUE_DEPTH) begin
               o.status = ST_FULL;
            end else begin
               waiter_ring[r*QUEUE_DEPTH + ring_tail[r]] = rq.pid[PID_BITS-1:0];
               ring_tail[r] = (ring_tail[r] + 1) % QUEUE_DEPTH;
               ring_fill[r]++;
               sem_count[r] = nc;
               o.status = ST_BLOCKED;
            end
         end else begin
            sem_count[r] = nc;
            o.status = ST_CONTINUE;
         end
      end else begin
         // count saturates at the top; a release that leaves the count at zero or below wakes the oldest waiter
         if (sem_count[r] < CNT_TOP) begin
            nc = sem_count[r] + 1;
            sem_count[r] = nc;
            if (nc <= 0 && ring_fill[r] > 0) begin
               o.woken_valid = 1'b1;
               o.woken_id = ID_BITS'(waiter_ring[r*QUEUE_DEPTH + ring_head[r]]);
               ring_head[r] = (ring_head[r] + 1) % QUEUE_DEPTH;
               ring_fill[r]--;
            end
         end
         o.status = ST_CONTINUE;
      end
      o.count_after = CNT_BITS'(sem_count[r]);
      return o;
   endfunction

   // register write, applied to the shadow bank at the same edge
   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx, input int unsigned value);
      int r;
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_RES_IN_USE) begin
         res_in_use = value & 7;
      end else if (idx >= CSR_INIT_0 && idx <= CSR_INIT_3) begin
         r = int'(idx - CSR_INIT_0);
         init_value[r] = value & 8'hff;
         reload_resource(r);
      end
   endtask

   task automatic push_req(input logic op, input int unsigned res, input int unsigned pid);
      semaphore_req_t rq;
      rq.op = op;
      rq.resource = RES_BITS'(res);
      rq.pid = ID_BITS'(pid);
      queued_requests.push_back(rq);
   endtask

   // hold the sender until every request is accepted and every outcome has come back
   task automatic wait_bank_idle();
      while (queued_requests.size() != 0 || req_tvalid || expected_outcomes.size() != 0)
         @(posedge clock);
   endtask

   // random traffic: mostly coherent sequences on live resources, some noise
   task automatic fill_segment(input int unsigned n_items);
      int unsigned made;
      int unsigned lim;
      int unsigned kind;
      int unsigned len;
      int unsigned r;
      int unsigned wait_pct;
      made = 0;
      lim = (res_in_use < NUM_RESOURCES) ? res_in_use : NUM_RESOURCES;
      while (made < n_items) begin
         kind = $urandom_range(0, 99);
         r = (lim == 0) ? $urandom_range(0, 15) : $urandom_range(0, lim - 1);
         if (lim == 0 || kind >= 80) begin
            // noise over the whole index range
            len = $urandom_range(1, 4);
            repeat (len)
               push_req($urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 255));
            made += len;
         end else if (kind < 45) begin
            // burst on one resource with a per-burst wait bias
            len = $urandom_range(4, 20);
            wait_pct = $urandom_range(20, 80);
            repeat (len)
               push_req(($urandom_range(0, 99) < wait_pct) ? OP_WAIT : OP_SIGNAL, r,
                        $urandom_range(0, 255));
            made += len;
         end else if (kind < 60) begin
            // pile waiters past the ring depth, then release them
            len = $urandom_range(QUEUE_DEPTH, QUEUE_DEPTH + 3);
            repeat (len) push_req(OP_WAIT, r, $urandom_range(0, 255));
            made += len;
            len = $urandom_range(QUEUE_DEPTH, QUEUE_DEPTH + 3);
            repeat (len) push_req(OP_SIGNAL, r, $urandom_range(0, 255));
            made += len;
         end else begin
            // mixed traffic across live resources
            len = $urandom_range(4, 12);
            repeat (len)
               push_req($urandom_range(0, 1), $urandom_range(0, lim - 1), $urandom_range(0, 255));
            made += len;
         end
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_outcomes.push_back(apply_semaphore_op(offered_req));
         if (!req_tvalid || req_tready) begin
            if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               offered_req = queued_requests.pop_front();
               req_tdata <= {3'b000, offered_req.pid, offered_req.resource, offered_req.op};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver back-pressure
   always @(posedge clock) begin
      semaphore_rsp_t got;
      semaphore_rsp_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[1:0];
            got.woken_valid = rsp_tdata[2];
            got.woken_id = rsp_tdata[10:3];
            got.count_after = rsp_tdata[19:11];
            if (expected_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result transfer with nothing outstanding: status %0d woken %0d/%0d count %0d",
                           $realtime, got.status, got.woken_valid, got.woken_id,
                           $signed(got.count_after));
            end else begin
               want = expected_outcomes.pop_front();
               if (got.status !== want.status || got.woken_valid !== want.woken_valid ||
                   got.woken_id !== want.woken_id || got.count_after !== want.count_after) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch: status %0d/%0d woken_valid %0d/%0d woken_id %0d/%0d count %0d/%0d (exp/got)",
                              $realtime, want.status, got.status, want.woken_valid,
                              got.woken_valid, want.woken_id, got.woken_id,
                              $signed(want.count_after), $signed(got.count_after));
               end
            end
         end
         // long hold-off when requested, otherwise random stalls
         if (stall_served != stall_requests && rsp_hold_left == 0) begin
            stall_served++;
            rsp_hold_left = RSP_HOLD_CYCLES;
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // watchdog on cycles with no transfer of any kind
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d cycles without a transfer", quiet_cycles);
            $display("FAIL");
            $finish;
         end
      end
   end

   // stimulus sequence
   initial begin
      int unsigned riu_plan[9];
      int unsigned v;
      riu_plan = '{4, 0, 7, 2, 4, 1, 5, 3, 4};
      res_in_use = 4;
      for (int k = 0; k < NUM_RESOURCES; k++) begin
         init_value[k] = 1;
         reload_resource(k);
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 26;
      recv_idle_pct = 86;

      // reset configuration: take, block, wake in order, unknown indices
      push_req(OP_WAIT, 0, 8'h00);
      push_req(OP_WAIT, 0, 8'hff);
      push_req(OP_WAIT, 0, 8'haa);
      push_req(OP_SIGNAL, 0, 8'h55);
      push_req(OP_SIGNAL, 0, 8'h00);
      push_req(OP_SIGNAL, 0, 8'h12);
      push_req(OP_WAIT, 3, 8'h0f);
      push_req(OP_SIGNAL, 15, 8'hf0);
      push_req(OP_WAIT, 4, 8'h01);
      push_req(OP_WAIT, 8, 8'h80);
      wait_bank_idle();

      // count at the top, a resource starting empty, fewer resources live
      csr_write(CSR_INIT_1, 255);
      csr_write(CSR_INIT_2, 0);
      csr_write(CSR_RES_IN_USE, 3);
      push_req(OP_SIGNAL, 1, 8'h33);
      push_req(OP_WAIT, 1, 8'h44);
      push_req(OP_SIGNAL, 1, 8'h66);
      push_req(OP_SIGNAL, 1, 8'h77);
      push_req(OP_WAIT, 3, 8'h88);
      push_req(OP_WAIT, 2, 8'h81);
      push_req(OP_SIGNAL, 2, 8'h7e);
      push_req(OP_WAIT, 0, 8'hc3);

      // three idle regimes, three configurations each
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 26 : (p == 1) ? 86 : 0;
         recv_idle_pct = (p == 0) ? 86 : (p == 1) ? 26 : 0;
         for (int s = 0; s < 3; s++) begin
            wait_bank_idle();
            csr_write(CSR_RES_IN_USE, riu_plan[p*3 + s]);
            for (int k = 0; k < NUM_RESOURCES; k++) begin
               if (p*3 + s == 0 || $urandom_range(0, 1) == 1) begin
                  case ($urandom_range(0, 9))
                     6: v = 255;
                     7: v = 254;
                     8: v = 0;
                     9: v = $urandom_range(0, 255);
                     default: v = $urandom_range(0, 3);
                  endcase
                  csr_write(CSR_INIT_0 + CSR_IDX_BITS'(k), v);
               end
            end
            fill_segment(SEGMENT_ITEMS);
            if (s == 1) stall_requests++;
         end
      end

      wait_bank_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_outcomes.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
